>>> design/bmhq_pkg.sv
// Shared constants, codes and control/status types for the binary heap queue.
`timescale 1ns / 1ps

package bmhq_pkg;

    localparam int CAPACITY = 16;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int CHILD_W  = ADDR_W + 2;
    localparam int KEY_W    = 32;
    localparam int ACT_W    = 2;
    localparam int CNTO_W   = 5;
    localparam int OUT_W    = 1 + KEY_W + CNTO_W + 1 + 1;

    // action codes
    localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
    localparam logic [ACT_W-1:0] ACT_REMOVE = 2'd1;
    localparam logic [ACT_W-1:0] ACT_CLEAR  = 2'd2;
    localparam logic [ACT_W-1:0] ACT_QUERY  = 2'd3;

    // count update
    localparam logic [1:0] CNT_HOLD = 2'd0;
    localparam logic [1:0] CNT_INC  = 2'd1;
    localparam logic [1:0] CNT_DEC  = 2'd2;
    localparam logic [1:0] CNT_CLR  = 2'd3;

    // position update
    localparam logic [1:0] POS_HOLD   = 2'd0;
    localparam logic [1:0] POS_COUNT  = 2'd1;
    localparam logic [1:0] POS_PARENT = 2'd2;
    localparam logic [1:0] POS_PICK   = 2'd3;

    // memory read select
    localparam logic [1:0] RD_NONE   = 2'd0;
    localparam logic [1:0] RD_PARENT = 2'd1;
    localparam logic [1:0] RD_LAST   = 2'd2;
    localparam logic [1:0] RD_CHILD  = 2'd3;

    // memory write select
    localparam logic [1:0] WR_NONE = 2'd0;
    localparam logic [1:0] WR_CUR  = 2'd1;
    localparam logic [1:0] WR_RDA  = 2'd2;
    localparam logic [1:0] WR_PICK = 2'd3;

    typedef struct packed {
        logic       load_key;
        logic       load_cur_rd;
        logic       done_we;
        logic       done_val;
        logic       pos_zero_ld;
        logic [1:0] cnt_op;
        logic [1:0] pos_op;
        logic [1:0] rd_sel;
        logic [1:0] wr_sel;
        logic       load_out;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
        logic pos_zero;
        logic left_oob;
        logic up_less;
        logic dn_stop;
    } stat_t;

endpackage

>>> design/bmhq_dpath.sv
// Heap datapath: key memory, count, sift position, compare logic and result register.
`timescale 1ns / 1ps

module bmhq_dpath (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  bmhq_pkg::cmd_t                         cmd,
    input  logic signed [bmhq_pkg::KEY_W-1:0]      s_key,
    output bmhq_pkg::stat_t                        stat,
    output logic [bmhq_pkg::OUT_W-1:0]             out_data
);

    logic signed [bmhq_pkg::KEY_W-1:0] mem [bmhq_pkg::CAPACITY];

    logic [bmhq_pkg::CNT_W-1:0]         count_reg, count_next;
    logic [bmhq_pkg::ADDR_W-1:0]        pos_reg, pos_next;
    logic signed [bmhq_pkg::KEY_W-1:0]  cur_reg, root_reg, rda_reg, rdb_reg, wdata;
    logic                               done_reg;
    logic [bmhq_pkg::OUT_W-1:0]         out_reg;

    logic [bmhq_pkg::ADDR_W-1:0]        parent, addr_a, addr_b, pick_pos;
    logic [bmhq_pkg::CHILD_W-1:0]       left_w, right_w, cnt_ext;
    logic                               right_ok, wr_en, rd_en;
    logic signed [bmhq_pkg::KEY_W-1:0]  pick_key, min_val;
    logic [bmhq_pkg::CNT_W+bmhq_pkg::CNTO_W-1:0] cnt_wide;

    assign parent  = (pos_reg - 1'b1) >> 1;
    assign left_w  = (bmhq_pkg::CHILD_W'(pos_reg) << 1) + 1'b1;
    assign right_w = left_w + 1'b1;
    assign cnt_ext = bmhq_pkg::CHILD_W'(count_reg);

    // right child only counts when it exists and is strictly smaller
    assign right_ok = (right_w < cnt_ext) && (rdb_reg < rda_reg);
    assign pick_key = right_ok ? rdb_reg : rda_reg;
    assign pick_pos = right_ok ? right_w[bmhq_pkg::ADDR_W-1:0] : left_w[bmhq_pkg::ADDR_W-1:0];

    always_comb begin
        addr_a = parent;
        addr_b = right_w[bmhq_pkg::ADDR_W-1:0];
        case (cmd.rd_sel)
            bmhq_pkg::RD_PARENT: addr_a = parent;
            bmhq_pkg::RD_LAST:   addr_a = count_reg[bmhq_pkg::ADDR_W-1:0];
            bmhq_pkg::RD_CHILD:  addr_a = left_w[bmhq_pkg::ADDR_W-1:0];
            default:             addr_a = parent;
        endcase
    end
    assign rd_en = (cmd.rd_sel != bmhq_pkg::RD_NONE);

    always_comb begin
        wdata = cur_reg;
        case (cmd.wr_sel)
            bmhq_pkg::WR_CUR:  wdata = cur_reg;
            bmhq_pkg::WR_RDA:  wdata = rda_reg;
            bmhq_pkg::WR_PICK: wdata = pick_key;
            default:           wdata = cur_reg;
        endcase
    end
    assign wr_en = (cmd.wr_sel != bmhq_pkg::WR_NONE);

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[pos_reg] <= wdata;
        end
        if (rd_en) begin
            rda_reg <= mem[addr_a];
            rdb_reg <= mem[addr_b];
        end
    end

    always_comb begin
        count_next = count_reg;
        case (cmd.cnt_op)
            bmhq_pkg::CNT_INC: count_next = count_reg + 1'b1;
            bmhq_pkg::CNT_DEC: count_next = count_reg - 1'b1;
            bmhq_pkg::CNT_CLR: count_next = '0;
            default:           count_next = count_reg;
        endcase
    end

    always_comb begin
        pos_next = pos_reg;
        if (cmd.pos_zero_ld) begin
            pos_next = '0;
        end else begin
            case (cmd.pos_op)
                bmhq_pkg::POS_COUNT:  pos_next = count_reg[bmhq_pkg::ADDR_W-1:0];
                bmhq_pkg::POS_PARENT: pos_next = parent;
                bmhq_pkg::POS_PICK:   pos_next = pick_pos;
                default:              pos_next = pos_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        pos_reg <= pos_next;
        if (cmd.load_key) begin
            cur_reg <= s_key;
        end else if (cmd.load_cur_rd) begin
            cur_reg <= rda_reg;
        end
        if (cmd.done_we) begin
            done_reg <= cmd.done_val;
        end
        if (wr_en && (pos_reg == '0)) begin
            root_reg <= wdata;
        end
    end

    assign cnt_wide = {{bmhq_pkg::CNTO_W{1'b0}}, count_reg};
    assign min_val  = (count_reg != '0) ? root_reg : '0;

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_reg <= {stat.full, stat.empty, cnt_wide[bmhq_pkg::CNTO_W-1:0], min_val, done_reg};
        end
    end
    assign out_data = out_reg;

    assign stat.full     = (count_reg == bmhq_pkg::CNT_W'(bmhq_pkg::CAPACITY));
    assign stat.empty    = (count_reg == '0);
    assign stat.pos_zero = (pos_reg == '0);
    assign stat.left_oob = (left_w >= cnt_ext);
    assign stat.up_less  = (cur_reg < rda_reg);
    assign stat.dn_stop  = (cur_reg < pick_key);

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= bmhq_pkg::CNT_W'(bmhq_pkg::CAPACITY))
        else $error("heap count beyond capacity");
    a_write_live: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> (bmhq_pkg::CNT_W'(pos_reg) < count_reg))
        else $error("heap write outside live slots");
    a_root_copy: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg != '0) && !wr_en && !(cmd.cnt_op == bmhq_pkg::CNT_DEC)
        |=> (count_reg == '0) || (root_reg == mem[0]) || $past(cmd.cnt_op != bmhq_pkg::CNT_HOLD))
        else $error("root copy differs from slot zero");
`endif

endmodule

>>> design/bmhq_ctrl.sv
// Sequencer for insert sift-up, remove sift-down and the result handshake.
`timescale 1ns / 1ps

module bmhq_ctrl (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [bmhq_pkg::ACT_W-1:0]    s_action,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    input  bmhq_pkg::stat_t               stat,
    output bmhq_pkg::cmd_t                cmd
);

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_UP_CHK  = 3'd1;
    localparam logic [2:0] ST_UP_CMP  = 3'd2;
    localparam logic [2:0] ST_DN_LAST = 3'd3;
    localparam logic [2:0] ST_DN_LOAD = 3'd4;
    localparam logic [2:0] ST_DN_CHK  = 3'd5;
    localparam logic [2:0] ST_DN_CMP  = 3'd6;
    localparam logic [2:0] ST_FIN     = 3'd7;

    logic [2:0] state_reg, state_next;
    logic       mvalid_reg, mvalid_next;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = mvalid_reg;

    always_comb begin
        state_next  = state_reg;
        mvalid_next = mvalid_reg && !m_tready;
        cmd         = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next   = ST_FIN;
                    cmd.done_we  = 1'b1;
                    cmd.done_val = 1'b1;
                    case (s_action)
                        bmhq_pkg::ACT_INSERT: begin
                            if (stat.full) begin
                                cmd.done_val = 1'b0;
                            end else begin
                                cmd.load_key = 1'b1;
                                cmd.pos_op   = bmhq_pkg::POS_COUNT;
                                cmd.cnt_op   = bmhq_pkg::CNT_INC;
                                state_next   = ST_UP_CHK;
                            end
                        end
                        bmhq_pkg::ACT_REMOVE: begin
                            if (stat.empty) begin
                                cmd.done_val = 1'b0;
                            end else begin
                                cmd.cnt_op = bmhq_pkg::CNT_DEC;
                                state_next = ST_DN_LAST;
                            end
                        end
                        bmhq_pkg::ACT_CLEAR: cmd.cnt_op = bmhq_pkg::CNT_CLR;
                        default: ;
                    endcase
                end
            end
            ST_UP_CHK: begin
                if (stat.pos_zero) begin
                    cmd.wr_sel = bmhq_pkg::WR_CUR;
                    state_next = ST_FIN;
                end else begin
                    cmd.rd_sel = bmhq_pkg::RD_PARENT;
                    state_next = ST_UP_CMP;
                end
            end
            ST_UP_CMP: begin
                if (stat.up_less) begin
                    cmd.wr_sel = bmhq_pkg::WR_RDA;
                    cmd.pos_op = bmhq_pkg::POS_PARENT;
                    state_next = ST_UP_CHK;
                end else begin
                    cmd.wr_sel = bmhq_pkg::WR_CUR;
                    state_next = ST_FIN;
                end
            end
            ST_DN_LAST: begin
                if (stat.empty) begin
                    state_next = ST_FIN;
                end else begin
                    cmd.rd_sel      = bmhq_pkg::RD_LAST;
                    cmd.pos_zero_ld = 1'b1;
                    state_next      = ST_DN_LOAD;
                end
            end
            ST_DN_LOAD: begin
                cmd.load_cur_rd = 1'b1;
                state_next      = ST_DN_CHK;
            end
            ST_DN_CHK: begin
                if (stat.left_oob) begin
                    cmd.wr_sel = bmhq_pkg::WR_CUR;
                    state_next = ST_FIN;
                end else begin
                    cmd.rd_sel = bmhq_pkg::RD_CHILD;
                    state_next = ST_DN_CMP;
                end
            end
            ST_DN_CMP: begin
                if (stat.dn_stop) begin
                    cmd.wr_sel = bmhq_pkg::WR_CUR;
                    state_next = ST_FIN;
                end else begin
                    cmd.wr_sel = bmhq_pkg::WR_PICK;
                    cmd.pos_op = bmhq_pkg::POS_PICK;
                    state_next = ST_DN_CHK;
                end
            end
            ST_FIN: begin
                if (!mvalid_reg || m_tready) begin
                    cmd.load_out = 1'b1;
                    mvalid_next  = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            mvalid_reg <= mvalid_next;
        end
    end

`ifndef SYNTHESIS
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second item taken while one is in progress");
    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> (!mvalid_reg || m_tready))
        else $error("result register overwritten while held");
    a_fin_leaves: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FIN) && !mvalid_reg |=> (state_reg == ST_IDLE) && mvalid_reg)
        else $error("finished item not moved to result register");
`endif

endmodule

>>> design/binary_min_heap_queue.sv
// Top level of the bounded min-priority queue kept as a binary heap.
//
// Input channel (s_): one item per action. s_tuser carries the action
// (insert, remove minimum, clear, query); s_tdata carries the signed key,
// used only by an insert.
// Result channel (m_): exactly one item per input item, in order: done flag,
// smallest key (0 when empty), count, empty and full flags.
// Flow: one item at a time. Query, clear and refused actions, and a remove
// that empties the queue, go straight to the result. An insert climbs the heap
// and a remove, after fetching the last key and starting at the root, descends
// it; with 16 slots that is at most 4 levels up and 3 down. The next item is
// taken once the result loads and the sequencer is back in idle. The heap
// memory has registered reads, so each level is a read state followed by a
// compare-and-write state.
// Reset: aresetn (synchronous, active low) empties the queue and drops any
// pending result; heap memory contents are not cleared.
// Stall: while m_tready is low the finished result holds in the output
// register; the next item is still accepted and worked, then waits for it.
`timescale 1ns / 1ps

module binary_min_heap_queue (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] key_value
    input  logic [1:0]  s_tuser,   // [1:0] action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // [0] done_res, [32:1] min_key, [37:33] entry_count,
                                   // [38] is_empty, [39] is_full
);

    bmhq_pkg::cmd_t  cmd;
    bmhq_pkg::stat_t stat;

    // sequencer: decodes the action and walks the sift loop
    bmhq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_action (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // heap storage, count and compare logic; holds the result item
    bmhq_dpath u_dpath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .s_key    (s_tdata),
        .stat     (stat),
        .out_data (m_tdata)
    );

endmodule
